/* src/rlcp_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED command packet parser package
// Shared types and constants for the packet parser and its checker.
// ----------------------------------------------------------------------------
package rlcp_pkg;

	localparam int COLOR_BYTES_DEF = 3;
	localparam int CFG_IDX_W       = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_HDR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_HDR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LIMIT   = 3'd4;

	// Register reset values
	localparam logic [7:0] COLOR_HDR_RST   = 8'd160;
	localparam logic [7:0] TIMEOUT_HDR_RST = 8'd161;
	localparam logic [7:0] TAIL_RST        = 8'd192;
	localparam logic [7:0] MIN_LIMIT_RST   = 8'd1;
	localparam logic [7:0] MAX_LIMIT_RST   = 8'd20;
	localparam logic [7:0] LIMIT_RST       = 8'd5;

	localparam logic [7:0] VERSION_BYTE = 8'h76;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [3:0] {
		EV_NONE          = 4'd0,
		EV_BYTE_TAKEN    = 4'd1,
		EV_VERSION       = 4'd2,
		EV_BAD_HEADER    = 4'd3,
		EV_TIMED_OUT     = 4'd4,
		EV_LIMIT_RANGE   = 4'd5,
		EV_BAD_TAIL      = 4'd6,
		EV_COLOR_APPLIED = 4'd7,
		EV_LIMIT_APPLIED = 4'd8
	} event_t;

	typedef struct packed {
		logic       command;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		event_t     event_code;
		logic [7:0] red_level;
		logic [7:0] green_level;
		logic [7:0] blue_level;
		logic [7:0] limit_now;
	} result_t;

endpackage

/* src/rgb_led_command_packet_parser.sv */
// ----------------------------------------------------------------------------
// RGB LED command packet parser
// Parses header, color or timeout payload and tail bytes; counts second ticks.
// ----------------------------------------------------------------------------
// Each item transfer writes its result into the output register. Throughput:
// one item per cycle unless a stalled result drops item_ready; the state update
// and result are one level of logic between the input handshake and the result
// register. Reset: arst_n clears phase, counters, applied color and limit (5 s)
// and the configuration registers to their defaults; no clearing pass is needed.
module rgb_led_command_packet_parser #(
	parameter int COLOR_BYTES = rlcp_pkg::COLOR_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  rlcp_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output rlcp_pkg::result_t              result,
	input  logic                           cfg_wen,
	input  logic [rlcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                     cfg_wdata
);
	import rlcp_pkg::*;

	localparam int IdxW = (COLOR_BYTES > 1) ? $clog2(COLOR_BYTES) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(COLOR_BYTES - 1);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_COLOR = 2'd1,
		PH_LIMIT = 2'd2,
		PH_TAIL  = 2'd3
	} phase_t;

	logic [7:0] color_hdr_q, timeout_hdr_q, tail_q, min_limit_q, max_limit_q;

	phase_t          phase_q, phase_d;
	logic            tail_kind_q, tail_kind_d;
	logic [IdxW-1:0] byte_idx_q, byte_idx_d;
	logic [7:0]      second_cnt_q, second_cnt_d;
	logic [7:0]      limit_q, limit_d;
	logic [7:0]      applied_q [COLOR_BYTES];
	logic            apply_color;
	logic [7:0]      pending_color_q [COLOR_BYTES];
	logic [7:0]      pending_limit_q;
	logic            write_color, write_limit;
	event_t          ev_d;
	logic [7:0]      tick_cnt;
	logic [7:0]      level_d [3];
	logic            take;

	assign take       = item_valid && item_ready;
	assign item_ready = !result_valid || result_ready;
	assign tick_cnt   = second_cnt_q + 8'd1;

	always_comb begin
		phase_d      = phase_q;
		tail_kind_d  = tail_kind_q;
		byte_idx_d   = byte_idx_q;
		second_cnt_d = second_cnt_q;
		limit_d      = limit_q;
		apply_color  = 1'b0;
		write_color  = 1'b0;
		write_limit  = 1'b0;
		ev_d         = EV_NONE;
		if (item.command == CMD_TICK) begin
			if (phase_q != PH_IDLE) begin
				second_cnt_d = tick_cnt;
				if (tick_cnt == limit_q) begin
					phase_d    = PH_IDLE;
					byte_idx_d = '0;
					ev_d       = EV_TIMED_OUT;
				end
			end
		end else begin
			ev_d = EV_BYTE_TAKEN;
			case (phase_q)
				PH_IDLE: begin
					// Color header wins over timeout header, both over the version byte.
					if (item.byte_value == color_hdr_q) begin
						phase_d      = PH_COLOR;
						byte_idx_d   = '0;
						second_cnt_d = '0;
					end else if (item.byte_value == timeout_hdr_q) begin
						phase_d      = PH_LIMIT;
						byte_idx_d   = '0;
						second_cnt_d = '0;
					end else if (item.byte_value == VERSION_BYTE) begin
						ev_d = EV_VERSION;
					end else begin
						ev_d = EV_BAD_HEADER;
					end
				end
				PH_COLOR: begin
					write_color = 1'b1;
					if (byte_idx_q == LastIdx) begin
						byte_idx_d  = '0;
						tail_kind_d = 1'b0;
						phase_d     = PH_TAIL;
					end else begin
						byte_idx_d = byte_idx_q + IdxW'(1);
					end
				end
				PH_LIMIT: begin
					write_limit = 1'b1;
					if (item.byte_value >= min_limit_q && item.byte_value <= max_limit_q) begin
						tail_kind_d = 1'b1;
						phase_d     = PH_TAIL;
					end else begin
						phase_d    = PH_IDLE;
						byte_idx_d = '0;
						ev_d       = EV_LIMIT_RANGE;
					end
				end
				default: begin
					if (item.byte_value == tail_q) begin
						if (!tail_kind_q) begin
							apply_color = 1'b1;
							ev_d        = EV_COLOR_APPLIED;
						end else begin
							limit_d = pending_limit_q;
							ev_d    = EV_LIMIT_APPLIED;
						end
					end else begin
						ev_d = EV_BAD_TAIL;
					end
					phase_d    = PH_IDLE;
					byte_idx_d = '0;
				end
			endcase
		end
	end

	// Result levels follow the color in force after this transfer.
	for (genvar i = 0; i < 3; i++) begin : g_level
		if (i < COLOR_BYTES) begin : g_used
			assign level_d[i] = apply_color ? pending_color_q[i] : applied_q[i];
		end else begin : g_unused
			assign level_d[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_hdr_q   <= COLOR_HDR_RST;
			timeout_hdr_q <= TIMEOUT_HDR_RST;
			tail_q        <= TAIL_RST;
			min_limit_q   <= MIN_LIMIT_RST;
			max_limit_q   <= MAX_LIMIT_RST;
			phase_q       <= PH_IDLE;
			tail_kind_q   <= 1'b0;
			byte_idx_q    <= '0;
			second_cnt_q  <= '0;
			limit_q       <= LIMIT_RST;
			for (int i = 0; i < COLOR_BYTES; i++) begin
				applied_q[i] <= '0;
			end
			result_valid  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_COLOR_HDR:   color_hdr_q   <= cfg_wdata;
					REG_TIMEOUT_HDR: timeout_hdr_q <= cfg_wdata;
					REG_TAIL:        tail_q        <= cfg_wdata;
					REG_MIN_LIMIT:   min_limit_q   <= cfg_wdata;
					REG_MAX_LIMIT:   max_limit_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (take) begin
				phase_q      <= phase_d;
				tail_kind_q  <= tail_kind_d;
				byte_idx_q   <= byte_idx_d;
				second_cnt_q <= second_cnt_d;
				limit_q      <= limit_d;
				if (apply_color) begin
					for (int i = 0; i < COLOR_BYTES; i++) begin
						applied_q[i] <= pending_color_q[i];
					end
				end
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// Payload registers: pending store and result, no reset needed.
	always_ff @(posedge clk) begin
		if (take) begin
			if (write_color) begin
				pending_color_q[byte_idx_q] <= item.byte_value;
			end
			if (write_limit) begin
				pending_limit_q <= item.byte_value;
			end
			result.event_code  <= ev_d;
			result.red_level   <= level_d[0];
			result.green_level <= level_d[1];
			result.blue_level  <= level_d[2];
			result.limit_now   <= limit_d;
		end
	end

endmodule

/* src/rlcp_checker.sv */
// ----------------------------------------------------------------------------
// RGB LED command packet parser checker
// Port-level assertions on handshake timing and result codes, bound to the top.
// ----------------------------------------------------------------------------
module rlcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input rlcp_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input rlcp_pkg::result_t result
);
	import rlcp_pkg::*;

	// A stalled result must hold until it is transferred.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Every accepted item yields a result in the next cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("accepted item produced no result");

	// An empty output stage never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output stage");

	// A tick can only report nothing or a timeout.
	a_tick_events: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.command == CMD_TICK |=>
			result.event_code == EV_NONE || result.event_code == EV_TIMED_OUT)
		else $error("tick produced a byte event");

	// A received byte always reports some event.
	a_byte_events: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.command == CMD_BYTE |=>
			result.event_code != EV_NONE && result.event_code != EV_TIMED_OUT)
		else $error("byte produced a tick event");

endmodule

bind rgb_led_command_packet_parser rlcp_checker u_rlcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

/* tb/rgb_led_command_packet_parser_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED command packet parser testbench
// Drives byte and tick items with random gaps and random output stalls, keeps
// an item-level model of the parser, and checks every result in order. The
// configuration is changed between phases: defaults, extreme codes and
// limits, random codes, an empty limit range, and equal header codes.
// ----------------------------------------------------------------------------
module rgb_led_command_packet_parser_tb;
	import rlcp_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COLOR,
		PH_LIMIT,
		PH_TAIL
	} parse_phase_t;

	class led_packet_scoreboard;
		logic [7:0]   color_hdr, timeout_hdr, tail_code, min_limit, max_limit;
		parse_phase_t phase;
		bit           tail_is_limit;
		int unsigned  color_idx;
		logic [7:0]   pending_rgb [COLOR_BYTES_DEF];
		logic [7:0]   applied_rgb [COLOR_BYTES_DEF];
		logic [7:0]   pending_limit, second_count, limit_seconds;
		result_t      expected_q [$];
		int unsigned  items_noted, failures;

		function new();
			color_hdr     = COLOR_HDR_RST;
			timeout_hdr   = TIMEOUT_HDR_RST;
			tail_code     = TAIL_RST;
			min_limit     = MIN_LIMIT_RST;
			max_limit     = MAX_LIMIT_RST;
			phase         = PH_IDLE;
			tail_is_limit = 1'b0;
			color_idx     = 0;
			foreach (pending_rgb[i]) begin
				pending_rgb[i] = '0;
				applied_rgb[i] = '0;
			end
			pending_limit = '0;
			second_count  = '0;
			limit_seconds = LIMIT_RST;
			items_noted   = 0;
			failures      = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			case (idx)
				REG_COLOR_HDR:   color_hdr = val;
				REG_TIMEOUT_HDR: timeout_hdr = val;
				REG_TAIL:        tail_code = val;
				REG_MIN_LIMIT:   min_limit = val;
				REG_MAX_LIMIT:   max_limit = val;
				default: ;
			endcase
		endfunction

		function event_t take_byte(logic [7:0] b);
			event_t ev;
			ev = EV_BYTE_TAKEN;
			case (phase)
				PH_IDLE: begin
					// Color header wins over timeout header, both over version.
					if (b == color_hdr) begin
						phase = PH_COLOR;
						color_idx = 0;
						second_count = '0;
					end else if (b == timeout_hdr) begin
						phase = PH_LIMIT;
						color_idx = 0;
						second_count = '0;
					end else if (b == VERSION_BYTE) begin
						ev = EV_VERSION;
					end else begin
						ev = EV_BAD_HEADER;
					end
				end
				PH_COLOR: begin
					pending_rgb[color_idx] = b;
					color_idx++;
					if (color_idx >= COLOR_BYTES_DEF) begin
						color_idx = 0;
						tail_is_limit = 1'b0;
						phase = PH_TAIL;
					end
				end
				PH_LIMIT: begin
					pending_limit = b;
					if (b >= min_limit && b <= max_limit) begin
						tail_is_limit = 1'b1;
						phase = PH_TAIL;
					end else begin
						phase = PH_IDLE;
						color_idx = 0;
						ev = EV_LIMIT_RANGE;
					end
				end
				default: begin
					if (b != tail_code) begin
						ev = EV_BAD_TAIL;
					end else if (tail_is_limit) begin
						limit_seconds = pending_limit;
						ev = EV_LIMIT_APPLIED;
					end else begin
						foreach (applied_rgb[i])
							applied_rgb[i] = pending_rgb[i];
						ev = EV_COLOR_APPLIED;
					end
					phase = PH_IDLE;
					color_idx = 0;
				end
			endcase
			return ev;
		endfunction

		function event_t take_tick();
			if (phase == PH_IDLE)
				return EV_NONE;
			// The counter wraps, so a zero limit fires on the 256th tick.
			second_count = second_count + 8'd1;
			if (second_count == limit_seconds) begin
				phase = PH_IDLE;
				color_idx = 0;
				return EV_TIMED_OUT;
			end
			return EV_NONE;
		endfunction

		function logic [7:0] rgb_level(int i);
			return (i < COLOR_BYTES_DEF) ? applied_rgb[i] : 8'h00;
		endfunction

		function void note_item(item_t it);
			result_t r;
			if (it.command == CMD_TICK)
				r.event_code = take_tick();
			else
				r.event_code = take_byte(it.byte_value);
			r.red_level   = rgb_level(0);
			r.green_level = rgb_level(1);
			r.blue_level  = rgb_level(2);
			r.limit_now   = limit_seconds;
			expected_q.push_back(r);
			items_noted++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: event %0d", got.event_code);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$write("mismatch: expected ev %0d rgb %h %h %h limit %0d, ",
						want.event_code, want.red_level, want.green_level,
						want.blue_level, want.limit_now);
					$display("got ev %0d rgb %h %h %h limit %0d",
						got.event_code, got.red_level, got.green_level,
						got.blue_level, got.limit_now);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	item_t                item;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	led_packet_scoreboard sb;
	bit                   no_gaps = 1'b0;
	int unsigned          cycle_count = 0;

	rgb_led_command_packet_parser uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	initial begin
		int ready_run;
		int stall_run;
		ready_run = 0;
		stall_run = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (ready_run == 0) begin
				ready_run = $urandom_range(1, 12);
				stall_run = pick_gap();
			end
			if (stall_run > 0) begin
				result_ready = 1'b0;
				stall_run--;
			end else begin
				result_ready = 1'b1;
				ready_run--;
			end
		end
	end

	// Valid stays high across back-to-back items; it drops only for a gap or a drain.
	task automatic send_item(item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid = 1'b1;
		item = it;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(it);
	endtask

	task automatic send_byte(logic [7:0] b);
		item_t it;
		it.command = CMD_BYTE;
		it.byte_value = b;
		send_item(it);
	endtask

	task automatic send_tick();
		item_t it;
		it.command = CMD_TICK;
		it.byte_value = 8'($urandom_range(0, 255));
		send_item(it);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_tick();
	endtask

	task automatic maybe_ticks();
		if ($urandom_range(0, 99) < 12)
			send_ticks($urandom_range(1, 3));
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_wen = 1'b0;
	endtask

	task automatic write_all_regs(logic [7:0] color_hdr, logic [7:0] timeout_hdr,
			logic [7:0] tail_code, logic [7:0] min_limit, logic [7:0] max_limit);
		write_reg(REG_COLOR_HDR, color_hdr);
		write_reg(REG_TIMEOUT_HDR, timeout_hdr);
		write_reg(REG_TAIL, tail_code);
		write_reg(REG_MIN_LIMIT, min_limit);
		write_reg(REG_MAX_LIMIT, max_limit);
	endtask

	function automatic logic [7:0] pick_tail();
		return ($urandom_range(0, 99) < 85) ? sb.tail_code : 8'($urandom_range(0, 255));
	endfunction

	// Mostly well-formed packets with random content, the rest noise.
	task automatic random_packet();
		int unsigned pick;
		int          n;
		item_t       it;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			send_byte(sb.color_hdr);
			repeat (COLOR_BYTES_DEF) begin
				maybe_ticks();
				send_byte(8'($urandom_range(0, 255)));
			end
			maybe_ticks();
			send_byte(pick_tail());
		end else if (pick < 55) begin
			send_byte(sb.timeout_hdr);
			maybe_ticks();
			if ($urandom_range(0, 99) < 80)
				send_byte(8'($urandom_range(sb.max_limit, sb.min_limit)));
			else
				send_byte(8'($urandom_range(0, 255)));
			maybe_ticks();
			send_byte(pick_tail());
		end else if (pick < 65) begin
			send_byte($urandom_range(0, 1) ? sb.color_hdr : sb.timeout_hdr);
			if ($urandom_range(0, 3) == 0)
				n = (sb.limit_seconds == 0) ? 256 : sb.limit_seconds;
			else
				n = $urandom_range(1, 10);
			send_ticks(n);
		end else if (pick < 72) begin
			send_byte(VERSION_BYTE);
		end else begin
			repeat ($urandom_range(1, 4)) begin
				it.command = 1'($urandom_range(0, 1));
				it.byte_value = 8'($urandom_range(0, 255));
				send_item(it);
			end
		end
	endtask

	task automatic random_run(int n);
		int unsigned target;
		target = sb.items_noted + n;
		while (sb.items_noted < target) begin
			// Occasionally hold the sender until everything has come back.
			if ($urandom_range(0, 99) < 3)
				drain();
			random_packet();
		end
	endtask

	initial begin
		logic [7:0] lo;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_wen = 1'b0;
		cfg_index = REG_COLOR_HDR;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default configuration: every event kind at least once.
		send_tick();
		send_byte(VERSION_BYTE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(COLOR_HDR_RST);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hAA);
		send_byte(TAIL_RST);
		send_byte(COLOR_HDR_RST);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'h55);
		send_byte(TIMEOUT_HDR_RST);
		send_byte(MAX_LIMIT_RST);
		send_byte(TAIL_RST);
		send_byte(TIMEOUT_HDR_RST);
		send_byte(8'd0);
		send_byte(TIMEOUT_HDR_RST);
		send_byte(MAX_LIMIT_RST + 8'd1);
		send_byte(TIMEOUT_HDR_RST);
		send_byte(MIN_LIMIT_RST);
		send_byte(TAIL_RST);
		send_byte(COLOR_HDR_RST);
		send_tick();
		send_byte(TIMEOUT_HDR_RST);
		send_byte(LIMIT_RST);
		send_byte(TAIL_RST);
		no_gaps = 1'b1;
		random_run(40);
		no_gaps = 1'b0;
		random_run(40);
		drain();

		// Extreme codes and the full limit range; a zero limit needs 256 ticks.
		write_all_regs(8'h00, 8'hFF, 8'h00, 8'd0, 8'd255);
		send_byte(8'hFF);
		send_byte(8'd0);
		send_byte(8'h00);
		send_byte(8'h00);
		send_ticks(256);
		send_byte(8'hFF);
		send_byte(8'd3);
		send_byte(8'h00);
		random_run(50);
		drain();

		// Random distinct headers and a narrow limit range.
		lo = 8'($urandom_range(1, 6));
		write_reg(REG_COLOR_HDR, 8'($urandom_range(0, 255)));
		write_reg(REG_TIMEOUT_HDR, sb.color_hdr ^ 8'($urandom_range(1, 255)));
		write_reg(REG_TAIL, 8'($urandom_range(0, 255)));
		write_reg(REG_MIN_LIMIT, lo);
		write_reg(REG_MAX_LIMIT, lo + 8'($urandom_range(0, 8)));
		random_run(50);
		drain();

		// Minimum above maximum: every limit byte is out of range.
		write_reg(REG_MIN_LIMIT, 8'd200);
		write_reg(REG_MAX_LIMIT, 8'd10);
		random_run(40);
		drain();

		// Equal header codes on the version byte: color header takes priority.
		write_all_regs(VERSION_BYTE, VERSION_BYTE, 8'hFF, 8'd255, 8'd255);
		send_byte(VERSION_BYTE);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		send_byte(8'hFF);
		drain();
		write_reg(REG_COLOR_HDR, 8'h10);
		send_byte(VERSION_BYTE);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(VERSION_BYTE);
		send_byte(8'hFE);
		random_run(30);
		drain();
		repeat (5) @(posedge clk);

		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
